[rtl/abps_pkg.sv]
// Shared types and constants for the all-occurrence byte pattern search block.
package abps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 4;
    localparam int LEN_CFG_W = 5;
    localparam int COUNT_W = 32;
    localparam int POS_W   = 32;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = POS_W + COUNT_W;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEXT = 1'b1;

    typedef enum logic [0:0] {
        OP_LOAD,
        OP_TEXT
    } op_kind_t;

    // One classified request as it sits in the queue.
    typedef struct packed {
        op_kind_t            kind;
        logic                slot_ok;
        logic [SLOT_W-1:0]   slot;
        logic [BYTE_W-1:0]   data;
        logic                last;
    } req_t;

endpackage

[rtl/abps_front.sv]
// Front end: accepts input requests, classifies them and pushes them into the queue.
module abps_front #(
    parameter int PATTERN_MAX = abps_pkg::PATTERN_MAX_DEF
) (
    input  logic                       s_func,
    input  logic [abps_pkg::BYTE_W-1:0] s_data_byte,
    input  logic [abps_pkg::SLOT_W-1:0] s_pattern_index,
    input  logic                       s_last_text,
    output abps_pkg::req_t             req
);
    import abps_pkg::*;

    always_comb
    begin
        req.data    = s_data_byte;
        req.slot    = s_pattern_index;
        // slots past the store are dropped by the back end
        req.slot_ok = (32'(s_pattern_index) < PATTERN_MAX);
        req.last    = s_last_text;
        unique case (s_func)
            FUNC_LOAD: req.kind = OP_LOAD;
            FUNC_TEXT: req.kind = OP_TEXT;
            default:   req.kind = OP_TEXT;
        endcase
    end

endmodule

[rtl/abps_queue.sv]
// Small register FIFO between front and back end.
module abps_queue #(
    parameter int DEPTH = abps_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  abps_pkg::req_t  push_req,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output abps_pkg::req_t  head
);
    import abps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    req_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

[rtl/abps_back.sv]
// Back end: pattern store, text window, comparators, counters and result register.
module abps_back #(
    parameter int PATTERN_MAX = abps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = abps_pkg::OFFSET_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [abps_pkg::LEN_CFG_W-1:0] cfg_wdata,
    input  logic                          req_valid,
    input  abps_pkg::req_t                req,
    output logic                          req_pop,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          res_found,
    output logic [abps_pkg::POS_W-1:0]    res_position,
    output logic [abps_pkg::COUNT_W-1:0]  res_total,
    output logic                          res_done
);
    import abps_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [LEN_CFG_W-1:0]   len_cfg_reg;
    logic [LEN_W-1:0]       len_eff;

    logic [BYTE_W-1:0]      pat_reg [PATTERN_MAX];
    logic [BYTE_W-1:0]      win_reg [PATTERN_MAX];
    logic [BYTE_W-1:0]      win_next [PATTERN_MAX];
    logic [BYTE_W-1:0]      win_shift [PATTERN_MAX];
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [COUNT_W-1:0]     count_reg, count_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   found_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [COUNT_W-1:0]     total_reg;
    logic                   done_reg;

    logic                   take, is_text, all_eq, hit, emit;
    logic [OFFSET_BITS-1:0] start;
    logic [63:0]            start_wide;

    // length clamp: 0 acts as 1, above the store acts as the store size
    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(len_cfg_reg) > PATTERN_MAX)
        begin
            len_eff = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_eff = LEN_W'(len_cfg_reg);
        end
    end

    assign req_pop = req_valid && (!out_valid_reg || res_ready);
    assign take    = req_pop;
    assign is_text = (req.kind == OP_TEXT);

    // window after this byte: slot 0 newest
    always_comb
    begin
        win_shift[0] = req.data;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            win_shift[k] = win_reg[k-1];
        end
    end

    // pattern slot j against the byte that arrived len-1-j steps ago
    always_comb
    begin
        logic [LEN_W-1:0] d;
        all_eq = 1'b1;
        d      = '0;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if (LEN_W'(j) < len_eff)
            begin
                d = len_eff - LEN_W'(1) - LEN_W'(j);
                if (pat_reg[j] != win_shift[d[IDX_W-1:0]])
                begin
                    all_eq = 1'b0;
                end
            end
        end
    end

    assign hit        = is_text && all_eq &&
                        (offset_reg >= OFFSET_BITS'(len_eff - LEN_W'(1)));
    assign emit       = take && is_text && (hit || req.last);
    assign start      = offset_reg + OFFSET_BITS'(1) - OFFSET_BITS'(len_eff);
    assign start_wide = 64'(start);

    always_comb
    begin
        win_next    = win_reg;
        offset_next = offset_reg;
        count_next  = count_reg;
        if (take && is_text)
        begin
            if (req.last)
            begin
                for (int k = 0; k < PATTERN_MAX; k++)
                begin
                    win_next[k] = '0;
                end
                offset_next = '0;
                count_next  = '0;
            end
            else
            begin
                win_next = win_shift;
                if (offset_reg != '1)
                begin
                    offset_next = offset_reg + 1'b1;
                end
                if (hit && (count_reg != '1))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg   <= LEN_CFG_W'(1);
            win_reg       <= '{default: '0};
            offset_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_cfg_reg <= cfg_wdata;
            end
            win_reg       <= win_next;
            offset_reg    <= offset_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // pattern store and result payload: no reset
    always_ff @(posedge clk)
    begin
        if (take && !is_text && req.slot_ok)
        begin
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                if (32'(req.slot) == k)
                begin
                    pat_reg[k] <= req.data;
                end
            end
        end
        if (emit)
        begin
            found_reg <= hit;
            pos_reg   <= hit ? start_wide[POS_W-1:0] : '0;
            total_reg <= (hit && (count_reg != '1)) ? count_reg + 1'b1 : count_reg;
            done_reg  <= req.last;
        end
    end

    assign res_valid    = out_valid_reg;
    assign res_found    = found_reg;
    assign res_position = pos_reg;
    assign res_total    = total_reg;
    assign res_done     = done_reg;

endmodule

[rtl/all_occurrence_byte_pattern_search.sv]
// Top level of the all-occurrence byte pattern search block.
//
// Finds every offset at which a loaded byte pattern occurs in a text stream,
// overlapping occurrences included. A request with tuser 0 writes one pattern
// byte into slot tdata[11:8]; slots at or past PATTERN_MAX are ignored. A
// request with tuser 1 presents one text byte; tlast marks the final byte of
// a text. When the newest pattern_length text bytes equal pattern slots
// 0..pattern_length-1, a result goes out with tuser 1, the start offset in
// tdata[31:0] and the running match count in tdata[63:32]. The final text
// byte always yields a result with tlast set (tuser 0 and offset 0 if it did
// not complete a match) and then clears offset, count and window. Offset and
// count saturate. Only pattern slots that were written may be compared.
// pattern_length is set through cfg_we/cfg_wdata, by the user only while the
// block is idle (the block does not enforce this); 0 acts as 1 and values
// past PATTERN_MAX act as PATTERN_MAX. Rate: one request per cycle unless
// the output stalls, for loads and text bytes alike; the back end retires one
// queued request per cycle through one shift of the window and PATTERN_MAX
// byte comparators in parallel. A request passes the queue register, then the
// result register. The 2-entry queue decouples input from output ready.
module all_occurrence_byte_pattern_search #(
    parameter int PATTERN_MAX = abps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = abps_pkg::OFFSET_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [abps_pkg::LEN_CFG_W-1:0]    cfg_wdata,   // pattern_length

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [abps_pkg::IN_DATA_W-1:0]    s_axis_tdata, // [7:0] data_byte, [11:8] pattern_index
    input  logic                              s_axis_tuser, // func
    input  logic                              s_axis_tlast, // last_text

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [abps_pkg::OUT_DATA_W-1:0]   m_axis_tdata, // [31:0] match_position, [63:32] match_total
    output logic                              m_axis_tuser, // match_found
    output logic                              m_axis_tlast  // done_res
);
    import abps_pkg::*;

    req_t              front_req;
    req_t              queue_head;
    logic              queue_full;
    logic              queue_not_empty;
    logic              queue_pop;
    logic [POS_W-1:0]  res_position;
    logic [COUNT_W-1:0] res_total;

    // classify the incoming request
    abps_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .s_func          (s_axis_tuser),
        .s_data_byte     (s_axis_tdata[BYTE_W-1:0]),
        .s_pattern_index (s_axis_tdata[BYTE_W+SLOT_W-1:BYTE_W]),
        .s_last_text     (s_axis_tlast),
        .req             (front_req)
    );

    assign s_axis_tready = !queue_full;

    // queue between front and back end
    abps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid),
        .push_req  (front_req),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head      (queue_head)
    );

    // window, comparators, counters, result register
    abps_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .req_valid    (queue_not_empty),
        .req          (queue_head),
        .req_pop      (queue_pop),
        .res_valid    (m_axis_tvalid),
        .res_ready    (m_axis_tready),
        .res_found    (m_axis_tuser),
        .res_position (res_position),
        .res_total    (res_total),
        .res_done     (m_axis_tlast)
    );

    assign m_axis_tdata = {res_total, res_position};

endmodule
